// ----- src/siren_tone_sequencer_macros.svh -----
// -----------------------------------------------------------------------------
// Siren tone sequencer assertion macros
// Concurrent property shorthands used by the port checker file.
// -----------------------------------------------------------------------------
`ifndef SIREN_TONE_SEQUENCER_MACROS_SVH
`define SIREN_TONE_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define STS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sts property violated");

// Next-cycle implication, disabled while reset is high.
`define STS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sts property violated");

`endif

// ----- src/sts_pkg.sv -----
// -----------------------------------------------------------------------------
// Siren tone sequencer package
// Mode and opcode codes, register map and shared types.
// -----------------------------------------------------------------------------
package sts_pkg;

  localparam int DIVISOR_W = 16;
  localparam int REG_IDX_W = 3;
  localparam int PADDR_W   = 5;

  typedef enum logic [2:0] {
    MODE_OFF    = 3'd0,
    MODE_ON     = 3'd1,
    MODE_BEEP   = 3'd2,
    MODE_WARN   = 3'd3,
    MODE_DANGER = 3'd4
  } mode_t;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_MODE = 2'd1;
  localparam logic [1:0] OP_BEEP = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_ON_FREQ    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BEEP_TIME  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WARN_MIN   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WARN_MAX   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WARN_SWEEP = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DNG_MIN    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DNG_MAX    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_DNG_SWEEP  = 3'd7;

  localparam logic [15:0] RST_ON_FREQ    = 16'd2000;
  localparam logic [15:0] RST_BEEP_TIME  = 16'd100;
  localparam logic [15:0] RST_WARN_MIN   = 16'd1000;
  localparam logic [15:0] RST_WARN_MAX   = 16'd2000;
  localparam logic [31:0] RST_WARN_SWEEP = 32'd655370;
  localparam logic [15:0] RST_DNG_MIN    = 16'd2000;
  localparam logic [15:0] RST_DNG_MAX    = 16'd4000;
  localparam logic [31:0] RST_DNG_SWEEP  = 32'd327730;

  typedef struct packed {
    logic [15:0] on_freq_hz;
    logic [15:0] beep_time_ms;
    logic [15:0] warn_min_hz;
    logic [15:0] warn_max_hz;
    logic [31:0] warn_sweep;
    logic [15:0] danger_min_hz;
    logic [15:0] danger_max_hz;
    logic [31:0] danger_sweep;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ----- src/sts_regs.sv -----
// -----------------------------------------------------------------------------
// Siren tone sequencer register file
// APB-style configuration registers with live read-back.
// -----------------------------------------------------------------------------
module sts_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sts_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output sts_pkg::cfg_t               cfg
);
  import sts_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_freq_hz    <= RST_ON_FREQ;
      cfg.beep_time_ms  <= RST_BEEP_TIME;
      cfg.warn_min_hz   <= RST_WARN_MIN;
      cfg.warn_max_hz   <= RST_WARN_MAX;
      cfg.warn_sweep    <= RST_WARN_SWEEP;
      cfg.danger_min_hz <= RST_DNG_MIN;
      cfg.danger_max_hz <= RST_DNG_MAX;
      cfg.danger_sweep  <= RST_DNG_SWEEP;
    end else if (wr_en) begin
      unique case (idx)
        REG_ON_FREQ:    cfg.on_freq_hz    <= pwdata[15:0];
        REG_BEEP_TIME:  cfg.beep_time_ms  <= pwdata[15:0];
        REG_WARN_MIN:   cfg.warn_min_hz   <= pwdata[15:0];
        REG_WARN_MAX:   cfg.warn_max_hz   <= pwdata[15:0];
        REG_WARN_SWEEP: cfg.warn_sweep    <= pwdata;
        REG_DNG_MIN:    cfg.danger_min_hz <= pwdata[15:0];
        REG_DNG_MAX:    cfg.danger_max_hz <= pwdata[15:0];
        REG_DNG_SWEEP:  cfg.danger_sweep  <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ON_FREQ:    prdata = {16'd0, cfg.on_freq_hz};
      REG_BEEP_TIME:  prdata = {16'd0, cfg.beep_time_ms};
      REG_WARN_MIN:   prdata = {16'd0, cfg.warn_min_hz};
      REG_WARN_MAX:   prdata = {16'd0, cfg.warn_max_hz};
      REG_WARN_SWEEP: prdata = cfg.warn_sweep;
      REG_DNG_MIN:    prdata = {16'd0, cfg.danger_min_hz};
      REG_DNG_MAX:    prdata = {16'd0, cfg.danger_max_hz};
      REG_DNG_SWEEP:  prdata = cfg.danger_sweep;
    endcase
  end

endmodule

// ----- src/sts_divider.sv -----
// -----------------------------------------------------------------------------
// Siren tone sequencer serial divider
// Radix-2 restoring divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module sts_divider #(
  parameter int DIV_W = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [DIV_W-1:0]              dividend,
  input  logic [sts_pkg::DIVISOR_W-1:0] divisor,
  output sts_pkg::div_status_t          status,
  output logic [DIV_W-1:0]              quotient
);
  import sts_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic                 done;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIV_W-1:0]     quo;
  logic [DIVISOR_W:0]   rem_sh;
  logic [DIVISOR_W:0]   rem_dif;
  logic                 ge;

  // Shift the next dividend bit into the partial remainder, try a subtract.
  assign rem_sh  = {rem, quo[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs};
  assign rem_dif = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? rem_dif[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;

endmodule

// ----- src/siren_tone_sequencer.sv -----
// Flow: an accepted beat with no tone to compute goes through ST_FINISH to its
// result beat; one with a tone goes through ST_DIV_CLK, ST_DIV_DUTY and ST_FINISH.
// A new beat is taken only in ST_IDLE, after the last result beat is loaded;
// a tone takes one pass through the serial divider (DIV_W bits, DIV_W =
// max(clog2(TIMER_CLOCK_HZ+1), 16)), and a result beat may wait for m_tready.
// Reset: synchronous, active high; clears mode, sweep, timers, timer registers
// and the output valid, and loads the configuration register defaults.
// -----------------------------------------------------------------------------
// Siren tone sequencer
// Buzzer mode controller: off, on, beep, warning and danger sweep alarms,
// driving PWM reload (shared serial divider) and compare (reload / DUTY_DIVISOR).
// -----------------------------------------------------------------------------
module siren_tone_sequencer #(
  parameter int TIMER_CLOCK_HZ = 1000000,
  parameter int RELOAD_MAX     = 65535,
  parameter int DUTY_DIVISOR   = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sts_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [39:0]                 s_tdata,  // new_mode[2:0], now_ms[34:3], zero pad
  input  logic [1:0]                  s_tuser,  // opcode[1:0]
  // result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [55:0]                 m_tdata   // mode[2:0], tone_freq_hz[18:3],
                                                // reload_value[34:19],
                                                // compare_value[50:35], zero pad
);
  import sts_pkg::*;

  // The divider has to hold the whole timer clock as a dividend, and at least
  // the 16 bits of a reload value as a quotient.
  localparam int CLK_W = $clog2(TIMER_CLOCK_HZ + 1);
  localparam int DIV_W = (CLK_W > 16) ? CLK_W : 16;

  // Duty divide by reciprocal: q = (r * DUTY_MUL) >> (16 + DUTY_SH), exact for
  // every 16-bit reload.
  localparam int          DUTY_SH  = $clog2(DUTY_DIVISOR);
  localparam logic [16:0] DUTY_MUL = 17'(((64'd1 << (16 + DUTY_SH)) +
                                          64'(DUTY_DIVISOR) - 64'd1) /
                                         64'(DUTY_DIVISOR));

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_CLK,
    ST_DIV_DUTY,
    ST_FINISH
  } state_t;

  cfg_t        cfg;
  div_status_t div_stat;
  state_t      state;

  mode_t       cur_mode;
  logic [15:0] sweep_freq;
  logic        sweep_down;
  logic [31:0] last_step_ms;
  logic [31:0] beep_start_ms;
  logic [15:0] reload_reg;
  logic [15:0] compare_reg;

  // Input fields
  logic [1:0]  opcode;
  logic [2:0]  new_mode;
  logic [31:0] now_ms;
  logic        accept;

  assign opcode   = s_tuser;
  assign new_mode = s_tdata[2:0];
  assign now_ms   = s_tdata[34:3];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid & s_tready;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  sts_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------------------
  // Item decode: everything but the divides settles at the accept edge.
  // ---------------------------------------------------------------------------
  logic        in_alarm;
  logic [15:0] lo_hz;
  logic [15:0] hi_hz;
  logic [31:0] sweep_cfg;
  logic [31:0] beep_elapsed;
  logic [31:0] step_elapsed;
  logic        beep_expired;
  logic        step_due;
  logic signed [17:0] step_sum;
  logic        step_hit_hi;
  logic        step_hit_lo;
  logic        nm_valid;

  mode_t       mode_next;
  logic [15:0] sweep_freq_next;
  logic        sweep_down_next;
  logic [31:0] last_step_next;
  logic [31:0] beep_start_next;
  logic        tone_go;      // play a tone of tone_f
  logic [15:0] tone_f;
  logic        silence;      // zero compare only
  logic        div_go;
  logic        compare_zero;

  assign in_alarm     = (cur_mode == MODE_WARN) || (cur_mode == MODE_DANGER);
  assign lo_hz        = (cur_mode == MODE_DANGER) ? cfg.danger_min_hz : cfg.warn_min_hz;
  assign hi_hz        = (cur_mode == MODE_DANGER) ? cfg.danger_max_hz : cfg.warn_max_hz;
  assign sweep_cfg    = (cur_mode == MODE_DANGER) ? cfg.danger_sweep  : cfg.warn_sweep;

  // Wrapping time differences
  assign beep_elapsed = now_ms - beep_start_ms;
  assign step_elapsed = now_ms - last_step_ms;
  assign beep_expired = beep_elapsed >= {16'd0, cfg.beep_time_ms};
  assign step_due     = step_elapsed >= {16'd0, sweep_cfg[31:16]};

  // Signed sum so a step below zero still clamps at the low end.
  assign step_sum = sweep_down ?
                    ($signed({2'b00, sweep_freq}) - $signed({2'b00, sweep_cfg[15:0]})) :
                    ($signed({2'b00, sweep_freq}) + $signed({2'b00, sweep_cfg[15:0]}));
  assign step_hit_hi = step_sum >= $signed({2'b00, hi_hz});
  assign step_hit_lo = step_sum <= $signed({2'b00, lo_hz});

  assign nm_valid = (new_mode <= 3'(MODE_DANGER)) && (new_mode != 3'(cur_mode));

  always_comb begin
    mode_next       = cur_mode;
    sweep_freq_next = sweep_freq;
    sweep_down_next = sweep_down;
    last_step_next  = last_step_ms;
    beep_start_next = beep_start_ms;
    tone_go         = 1'b0;
    tone_f          = cfg.on_freq_hz;
    silence         = 1'b0;
    unique case (opcode)
      OP_TICK: begin
        if (cur_mode == MODE_BEEP) begin
          // Beep times out to off.
          if (beep_expired) begin
            mode_next = MODE_OFF;
            silence   = 1'b1;
          end
        end else if (in_alarm && step_due) begin
          // Advance the triangle sweep; the high end is tested first.
          last_step_next = now_ms;
          tone_go        = 1'b1;
          if (step_hit_hi) begin
            sweep_freq_next = hi_hz;
            sweep_down_next = 1'b1;
          end else if (step_hit_lo) begin
            sweep_freq_next = lo_hz;
            sweep_down_next = 1'b0;
          end else begin
            sweep_freq_next = step_sum[15:0];
          end
          tone_f = sweep_freq_next;
        end
      end
      OP_MODE: begin
        if (nm_valid) begin
          mode_next = mode_t'(new_mode);
          if (mode_t'(new_mode) == MODE_OFF) begin
            silence = 1'b1;
          end else if (mode_t'(new_mode) == MODE_ON) begin
            tone_go = 1'b1;
          end else if (mode_t'(new_mode) == MODE_BEEP) begin
            beep_start_next = now_ms;
            tone_go         = 1'b1;
          end else begin
            // Enter an alarm at its low end, sweeping upward.
            sweep_freq_next = (mode_t'(new_mode) == MODE_DANGER) ?
                              cfg.danger_min_hz : cfg.warn_min_hz;
            sweep_down_next = 1'b0;
            last_step_next  = now_ms;
            tone_go         = 1'b1;
            tone_f          = sweep_freq_next;
          end
        end
      end
      OP_BEEP: begin
        // Ignored during an alarm; restarts a running beep.
        if (!in_alarm) begin
          mode_next       = MODE_BEEP;
          beep_start_next = now_ms;
          tone_go         = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign div_go       = tone_go && (tone_f != 16'd0);
  assign compare_zero = silence || (tone_go && (tone_f == 16'd0));

  // ---------------------------------------------------------------------------
  // Shared divider: TIMER_CLOCK_HZ / f; the duty step multiplies by a constant.
  // ---------------------------------------------------------------------------
  logic                 div_start;
  logic [DIV_W-1:0]     div_dividend;
  logic [DIVISOR_W-1:0] div_divisor;
  logic [DIV_W-1:0]     div_quo;
  logic [DIV_W-1:0]     quo_minus;
  logic [15:0]          reload_calc;
  logic [32:0]          duty_prod;
  logic [15:0]          compare_calc;

  assign div_start    = accept && div_go;
  assign div_dividend = DIV_W'(TIMER_CLOCK_HZ);
  assign div_divisor  = tone_f;

  sts_divider #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_stat),
    .quotient (div_quo)
  );

  // Reload = quotient - 1, held at zero for a zero quotient, saturated at the top.
  assign quo_minus   = div_quo - DIV_W'(1);
  assign reload_calc = (div_quo == '0) ? 16'd0 :
                       (quo_minus > DIV_W'(RELOAD_MAX)) ? 16'(RELOAD_MAX) :
                       quo_minus[15:0];

  // Compare = reload / DUTY_DIVISOR from the latched reload.
  assign duty_prod    = {17'd0, reload_reg} * {16'd0, DUTY_MUL};
  assign compare_calc = 16'(duty_prod >> (16 + DUTY_SH));

  // ---------------------------------------------------------------------------
  // Sequencer and result register
  // ---------------------------------------------------------------------------
  logic [15:0] tone_out;

  assign tone_out = in_alarm ? sweep_freq : 16'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cur_mode      <= MODE_OFF;
      sweep_freq    <= '0;
      sweep_down    <= 1'b0;
      last_step_ms  <= '0;
      beep_start_ms <= '0;
      reload_reg    <= '0;
      compare_reg   <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one loads below.
      if (m_tvalid && m_tready && (state != ST_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cur_mode      <= mode_next;
            sweep_freq    <= sweep_freq_next;
            sweep_down    <= sweep_down_next;
            last_step_ms  <= last_step_next;
            beep_start_ms <= beep_start_next;
            if (compare_zero) begin
              compare_reg <= '0;
            end
            state <= div_go ? ST_DIV_CLK : ST_FINISH;
          end
        end
        ST_DIV_CLK: begin
          // Latch reload once the divide is done.
          if (div_stat.done) begin
            reload_reg <= reload_calc;
            state      <= ST_DIV_DUTY;
          end
        end
        ST_DIV_DUTY: begin
          compare_reg <= compare_calc;
          state       <= ST_FINISH;
        end
        ST_FINISH: begin
          // Hold until the result register is free.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'd0, compare_reg, reload_reg, tone_out, 3'(cur_mode)};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/sts_checker.sv -----
// -----------------------------------------------------------------------------
// Siren tone sequencer port checker
// Port-level properties of the sequencer, bound to the top level.
// -----------------------------------------------------------------------------
`include "siren_tone_sequencer_macros.svh"

module sts_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);
  import sts_pkg::*;

  logic [2:0]  out_mode;
  logic [15:0] out_tone;
  logic [15:0] out_reload;
  logic [15:0] out_compare;

  assign out_mode    = m_tdata[2:0];
  assign out_tone    = m_tdata[18:3];
  assign out_reload  = m_tdata[34:19];
  assign out_compare = m_tdata[50:35];

  // A stalled result beat holds.
  `STS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // One beat at a time: the block is busy right after an accept.
  `STS_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)

  // Compare is reload divided down, or zero for silence.
  `STS_ASSERT_SAME(a_compare_le_reload, clk, rst, m_tvalid, out_compare <= out_reload)

  // Sweep frequency shows only in the alarm modes.
  `STS_ASSERT_SAME(a_tone_only_alarm, clk, rst,
    m_tvalid && (out_mode != 3'(MODE_WARN)) && (out_mode != 3'(MODE_DANGER)), out_tone == 16'd0)

endmodule

bind siren_tone_sequencer sts_checker u_sts_checker (.*);
